// File: hw/rtl/pds_pkg.sv
// Shared types, constants and helpers of the polyline distance sampler.
`timescale 1ns / 1ps
`default_nettype none
package pds_pkg;

    localparam int MAX_POINTS = 1024;
    localparam logic [16:0] FRAC_ONE = 17'd65536;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [17:0] uz;
    } t_point;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SEEK = 2'd1,
        OP_MOVE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        AR_MUL,
        AR_SQRT,
        AR_DIV
    } t_arith_op;

    typedef struct packed {
        logic         go;
        t_arith_op    op;
        logic [67:0]  opa;
        logic [33:0]  opb;
    } t_arith_req;

    typedef struct packed {
        logic         done;
        logic [67:0]  result;
    } t_arith_rsp;

    // Component k of a point, sign extended to 33 bits (0..2 position, 3..5 up).
    function automatic logic signed [32:0] point_comp(input t_point p, input logic [2:0] k);
        logic signed [32:0] v;
        begin
            case (k)
                3'd0: v = {p.px[31], p.px};
                3'd1: v = {p.py[31], p.py};
                3'd2: v = {p.pz[31], p.pz};
                3'd3: v = {{15{p.ux[17]}}, p.ux};
                3'd4: v = {{15{p.uy[17]}}, p.uy};
                3'd5: v = {{15{p.uz[17]}}, p.uz};
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pds_point_mem.sv
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pds_point_mem
    import pds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [9:0]  i_waddr,
    input  wire t_point      i_wdata,
    input  wire logic [9:0]  i_raddr,
    output t_point           o_rdata
);

    t_point r_mem [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/pds_arith.sv
// Shared bit-serial unit: multiply, integer square root and fraction divide.
`timescale 1ns / 1ps
`default_nettype none
module pds_arith
    import pds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_arith_req i_req,
    output t_arith_rsp      o_rsp
);

    logic         r_busy;
    logic         r_done;
    t_arith_op    r_op;
    logic [5:0]   r_cnt;
    logic [67:0]  r_acc;
    logic [33:0]  r_m;
    logic [36:0]  r_rem;
    logic [33:0]  r_root;

    logic [34:0]  w_msum;
    logic [36:0]  w_srem;
    logic [36:0]  w_trial;
    logic [36:0]  w_drem;
    logic [5:0]   w_last;

    assign w_msum  = {1'b0, r_acc[67:34]} + (r_acc[0] ? {1'b0, r_m} : 35'd0);
    assign w_srem  = {r_rem[34:0], r_acc[67:66]};
    assign w_trial = {1'b0, r_root, 2'b01};
    // The first divide step produces the integer bit, so a numerator equal to the
    // divisor yields a full fraction of one.
    assign w_drem  = (r_cnt == 6'd0) ? r_rem : {r_rem[35:0], 1'b0};
    assign w_last  = (r_op == AR_DIV) ? 6'd16 : 6'd33;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.go) begin
                    r_busy <= 1'b1;
                    r_op   <= i_req.op;
                    r_cnt  <= '0;
                    r_root <= '0;
                    case (i_req.op)
                        AR_MUL: begin
                            r_acc <= {34'd0, i_req.opb};
                            r_m   <= i_req.opa[33:0];
                        end
                        AR_SQRT: begin
                            r_acc <= i_req.opa;
                            r_rem <= '0;
                            r_m   <= i_req.opb;
                        end
                        default: begin
                            r_rem <= {3'd0, i_req.opa[33:0]};
                            r_m   <= i_req.opb;
                        end
                    endcase
                end
            end else begin
                case (r_op)
                    AR_MUL: begin
                        r_acc <= {w_msum, r_acc[33:1]};
                    end
                    AR_SQRT: begin
                        r_acc <= {r_acc[65:0], 2'b00};
                        if (w_srem >= w_trial) begin
                            r_rem  <= w_srem - w_trial;
                            r_root <= {r_root[32:0], 1'b1};
                        end else begin
                            r_rem  <= w_srem;
                            r_root <= {r_root[32:0], 1'b0};
                        end
                    end
                    default: begin
                        if (w_drem >= {3'd0, r_m}) begin
                            r_rem  <= w_drem - {3'd0, r_m};
                            r_root <= {r_root[32:0], 1'b1};
                        end else begin
                            r_rem  <= w_drem;
                            r_root <= {r_root[32:0], 1'b0};
                        end
                    end
                endcase
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == AR_MUL) ? r_acc : {34'd0, r_root};

endmodule
`default_nettype wire

// File: hw/rtl/polyline_distance_sampler_top.sv
// Top level of the polyline distance sampler: walk sequencer and result registers.
`timescale 1ns / 1ps
// A load or an unknown request strobes its result after a point fetch and six
// interpolation multiplies. A seek or move first examines segments, each with three
// squares, a square root and a fraction multiply (one bit per cycle in the shared
// unit), and adds a final divide when it rests inside.
// Throughput: one request at a time; busy stays high until the one-cycle result strobe,
// which the receiver cannot stall. Reset clears cursor, count and control, not the store.
`default_nettype none
module polyline_distance_sampler_top
    import pds_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [10:0]        i_cfg_wdata,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic [1:0]         i_operation,
    input  wire logic [9:0]         i_point_index,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [17:0] i_up_x,
    input  wire logic signed [17:0] i_up_y,
    input  wire logic signed [17:0] i_up_z,
    input  wire logic signed [31:0] i_distance,
    output      logic               o_strobe,
    output      logic signed [31:0] o_leftover,
    output      logic               o_inside_res,
    output      logic [9:0]         o_cursor_segment,
    output      logic [16:0]        o_cursor_fraction,
    output      logic signed [31:0] o_sample_x,
    output      logic signed [31:0] o_sample_y,
    output      logic signed [31:0] o_sample_z,
    output      logic signed [17:0] o_sample_up_x,
    output      logic signed [17:0] o_sample_up_y,
    output      logic signed [17:0] o_sample_up_z
);

    // The sequencer walks one segment per pass: it fetches both end points,
    // squares the three coordinate differences, takes the square root for the
    // segment length, scales the current fraction by that length and then
    // decides whether the walk passes the segment or comes to rest in it.
    // The same fetch and multiply states serve the final interpolation.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SAMPLE,
        S_FETCH_A,
        S_FETCH_B,
        S_FETCH_W,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_FMUL_GO,
        S_FMUL_WAIT,
        S_DECIDE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [10:0]         r_pc;
    logic [9:0]          r_seg;
    logic [16:0]         r_frac;
    logic signed [35:0]  r_dist;
    logic signed [31:0]  r_left;
    logic                r_inside;
    logic                r_smp_phase;
    logic                r_fwd;
    logic [2:0]          r_k;
    logic [65:0]         r_sq;
    logic [33:0]         r_len;
    logic [33:0]         r_s;
    t_point              r_pa;
    t_point              r_pb;
    logic [31:0]         r_smp [6];

    t_point              w_rdata;
    t_point              w_wdata;
    logic                w_we;
    logic                w_accept;
    logic [10:0]         w_n;
    logic [9:0]          w_last;
    logic [10:0]         w_seg1;
    logic                w_tail;
    logic [9:0]          w_addr_a;
    logic [9:0]          w_addr_b;
    logic [9:0]          w_raddr;
    logic signed [32:0]  w_ca;
    logic signed [32:0]  w_cb;
    logic signed [32:0]  w_diff;
    logic                w_neg;
    logic [32:0]         w_mag;
    logic [49:0]         w_prod;
    logic signed [50:0]  w_sp;
    logic signed [50:0]  w_sh;
    logic [31:0]         w_val;
    logic [33:0]         w_remain;
    logic                w_fwd_pass;
    logic                w_bwd_pass;
    logic signed [35:0]  w_num;
    logic                w_stale;
    logic signed [35:0]  w_dist_in;
    t_arith_req          w_req;
    t_arith_rsp          w_rsp;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_we     = w_accept && (t_op'(i_operation) == OP_LOAD);

    assign w_wdata.px = i_pos_x;
    assign w_wdata.py = i_pos_y;
    assign w_wdata.pz = i_pos_z;
    assign w_wdata.ux = i_up_x;
    assign w_wdata.uy = i_up_y;
    assign w_wdata.uz = i_up_z;

    // A count above the store depth is used as the full store.
    assign w_n    = (r_pc > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : r_pc;
    assign w_last = 10'(w_n - 11'd1);
    assign w_seg1 = {1'b0, r_seg} + 11'd1;
    assign w_tail = (w_seg1 >= w_n);

    // While walking, the second point is the next one, clamped to the last point.
    // While sampling, a cursor at or past the last point reads the last point twice,
    // so the interpolation returns that point unchanged.
    always_comb begin
        if (r_smp_phase) begin
            w_addr_a = w_tail ? w_last : r_seg;
            w_addr_b = w_tail ? w_last : w_seg1[9:0];
        end else begin
            w_addr_a = r_seg;
            w_addr_b = w_tail ? w_last : w_seg1[9:0];
        end
    end
    assign w_raddr = (r_state == S_FETCH_A) ? w_addr_a : w_addr_b;

    assign w_ca   = point_comp(r_pa, r_k);
    assign w_cb   = point_comp(r_pb, r_k);
    assign w_diff = w_cb - w_ca;
    assign w_neg  = w_diff[32];
    assign w_mag  = w_neg ? 33'(-w_diff) : 33'(w_diff);

    // Interpolation: a + floor((b - a) * f / 65536), with the floor taken by an
    // arithmetic shift of the signed product.
    assign w_prod = w_rsp.result[49:0];
    assign w_sp   = w_neg ? -$signed({1'b0, w_prod}) : $signed({1'b0, w_prod});
    assign w_sh   = w_sp >>> 16;
    assign w_val  = w_ca[31:0] + w_sh[31:0];

    assign w_remain   = r_len - r_s;
    assign w_fwd_pass = (r_dist >= $signed({2'b00, w_remain}));
    assign w_bwd_pass = (r_dist <= -$signed({2'b00, r_s}));
    assign w_num      = r_dist + $signed({2'b00, r_s});
    assign w_stale    = ({1'b0, r_seg} >= w_n);
    assign w_dist_in  = 36'(i_distance);

    always_comb begin
        w_req.go  = 1'b0;
        w_req.op  = AR_MUL;
        w_req.opa = '0;
        w_req.opb = '0;
        case (r_state)
            S_MUL_GO: begin
                w_req.go  = 1'b1;
                w_req.opa = {35'd0, w_mag};
                w_req.opb = r_smp_phase ? {17'd0, r_frac} : {1'b0, w_mag};
            end
            S_SQRT_GO: begin
                w_req.go  = 1'b1;
                w_req.op  = AR_SQRT;
                w_req.opa = {2'b00, r_sq};
            end
            S_FMUL_GO: begin
                w_req.go  = 1'b1;
                w_req.opa = {34'd0, r_len};
                w_req.opb = {17'd0, r_frac};
            end
            S_DIV_GO: begin
                w_req.go  = 1'b1;
                w_req.op  = AR_DIV;
                w_req.opa = {34'd0, w_num[33:0]};
                w_req.opb = r_len;
            end
            default: begin
                w_req.go = 1'b0;
            end
        endcase
    end

    pds_point_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_point_index),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pds_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_seg    <= '0;
            r_frac   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_left   <= '0;
                        r_inside <= 1'b0;
                        r_dist   <= w_dist_in;
                        case (t_op'(i_operation))
                            OP_SEEK: begin
                                // Negative seeks start from the end of the path.
                                if (i_distance < 0 && w_n >= 11'd2) begin
                                    r_seg  <= w_last;
                                    r_frac <= FRAC_ONE;
                                end else begin
                                    r_seg  <= '0;
                                    r_frac <= '0;
                                end
                                r_state <= S_PREP;
                            end
                            OP_MOVE: begin
                                r_state <= S_PREP;
                            end
                            default: begin
                                r_state <= S_SAMPLE;
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    r_smp_phase <= 1'b0;
                    // The direction is fixed here, since the distance still to go
                    // can run down to zero in the middle of a walk.
                    r_fwd       <= (r_dist > 0);
                    if (r_dist == 0 || w_n == 11'd0) begin
                        r_state <= S_SAMPLE;
                    end else if (w_n == 11'd1) begin
                        r_seg   <= '0;
                        r_frac  <= '0;
                        r_state <= S_SAMPLE;
                    end else if (r_dist > 0 && (w_stale || w_seg1 >= w_n)) begin
                        // Already at the far end: nothing to walk.
                        r_seg   <= w_last;
                        r_frac  <= FRAC_ONE;
                        r_left  <= r_dist[31:0];
                        r_state <= S_SAMPLE;
                    end else begin
                        if (w_stale) begin
                            r_seg  <= w_last;
                            r_frac <= FRAC_ONE;
                        end
                        r_state <= S_FETCH_A;
                    end
                end
                S_SAMPLE: begin
                    r_smp_phase <= 1'b1;
                    if (w_n == 11'd0) begin
                        r_smp[0] <= '0;
                        r_smp[1] <= '0;
                        r_smp[2] <= '0;
                        r_smp[3] <= '0;
                        r_smp[4] <= '0;
                        r_smp[5] <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FETCH_A;
                    end
                end
                S_FETCH_A: begin
                    r_state <= S_FETCH_B;
                end
                S_FETCH_B: begin
                    r_pa    <= w_rdata;
                    r_state <= S_FETCH_W;
                end
                S_FETCH_W: begin
                    r_pb    <= w_rdata;
                    r_k     <= '0;
                    r_sq    <= '0;
                    r_state <= S_MUL_GO;
                end
                S_MUL_GO: begin
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_smp_phase) begin
                            r_smp[r_k] <= w_val;
                            if (r_k == 3'd5) begin
                                r_state <= S_DONE;
                            end else begin
                                r_k     <= r_k + 3'd1;
                                r_state <= S_MUL_GO;
                            end
                        end else begin
                            r_sq <= r_sq + w_rsp.result[65:0];
                            if (r_k == 3'd2) begin
                                r_state <= S_SQRT_GO;
                            end else begin
                                r_k     <= r_k + 3'd1;
                                r_state <= S_MUL_GO;
                            end
                        end
                    end
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (w_rsp.done) begin
                        r_len   <= w_rsp.result[33:0];
                        r_state <= S_FMUL_GO;
                    end
                end
                S_FMUL_GO: begin
                    r_state <= S_FMUL_WAIT;
                end
                S_FMUL_WAIT: begin
                    if (w_rsp.done) begin
                        r_s     <= w_rsp.result[49:16];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_fwd) begin
                        if (w_fwd_pass) begin
                            // Pass this segment; a zero-length one is passed for free.
                            if ({1'b0, r_seg} + 11'd2 < w_n) begin
                                r_dist  <= r_dist - $signed({2'b00, w_remain});
                                r_seg   <= r_seg + 10'd1;
                                r_frac  <= '0;
                                r_state <= S_FETCH_A;
                            end else begin
                                r_left  <= 32'(r_dist - $signed({2'b00, w_remain}));
                                r_seg   <= w_last;
                                r_frac  <= FRAC_ONE;
                                r_state <= S_SAMPLE;
                            end
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end else begin
                        if (w_bwd_pass) begin
                            if (r_seg == '0) begin
                                r_left  <= w_num[31:0];
                                r_frac  <= '0;
                                r_state <= S_SAMPLE;
                            end else begin
                                r_dist  <= w_num;
                                r_seg   <= r_seg - 10'd1;
                                r_frac  <= FRAC_ONE;
                                r_state <= S_FETCH_A;
                            end
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        // The walk rests inside this segment.
                        r_frac   <= w_rsp.result[16:0];
                        r_inside <= 1'b1;
                        r_left   <= '0;
                        r_state  <= S_SAMPLE;
                    end
                end
                S_DONE: begin
                    o_strobe          <= 1'b1;
                    o_leftover        <= r_left;
                    o_inside_res      <= r_inside;
                    o_cursor_segment  <= r_seg;
                    o_cursor_fraction <= r_frac;
                    o_sample_x        <= r_smp[0];
                    o_sample_y        <= r_smp[1];
                    o_sample_z        <= r_smp[2];
                    o_sample_up_x     <= r_smp[3][17:0];
                    o_sample_up_y     <= r_smp[4][17:0];
                    o_sample_up_z     <= r_smp[5][17:0];
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: verif/polyline_distance_sampler_top_tb.sv
// Self-checking testbench for the polyline distance sampler top level.
`timescale 1ns / 1ps
module polyline_distance_sampler_top_tb;
    import pds_pkg::*;

    // One expected or observed result of a request.
    typedef struct {
        logic [31:0] leftover;
        logic        in_path;
        logic [9:0]  seg;
        logic [16:0] frac;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [17:0] sux;
        logic [17:0] suy;
        logic [17:0] suz;
    } walk_result_t;

    // Cursor and point store predictor plus the queue of walk results still due.
    class walk_scoreboard;
        int px[MAX_POINTS];
        int py[MAX_POINTS];
        int pz[MAX_POINTS];
        int ux[MAX_POINTS];
        int uy[MAX_POINTS];
        int uz[MAX_POINTS];
        int unsigned count_reg;
        int unsigned seg_idx;
        int unsigned seg_frac;
        walk_result_t due_q[$];
        int errors;

        function void set_count(int unsigned v);
            count_reg = v;
        endfunction

        function int unsigned points_in_use();
            return (count_reg > MAX_POINTS) ? MAX_POINTS : count_reg;
        endfunction

        function bit pending();
            return due_q.size() != 0;
        endfunction

        // Floor of the Euclidean distance between points i and j, Q16.16.
        function longint unsigned seg_len(int unsigned i, int unsigned j);
            logic [69:0] ax, ay, az, acc, sq;
            logic [33:0] r, c;
            longint d;
            d = longint'(px[j]) - longint'(px[i]);
            ax = (d < 0) ? -d : d;
            d = longint'(py[j]) - longint'(py[i]);
            ay = (d < 0) ? -d : d;
            d = longint'(pz[j]) - longint'(pz[i]);
            az = (d < 0) ? -d : d;
            acc = ax * ax + ay * ay + az * az;
            r = '0;
            for (int k = 33; k >= 0; k--) begin
                c = r | (34'd1 << k);
                sq = {36'b0, c} * {36'b0, c};
                if (sq <= acc) r = c;
            end
            return longint'(r);
        endfunction

        function longint interp(int a, int b, int unsigned f);
            return longint'(a) + (((longint'(b) - longint'(a)) * longint'(f)) >>> 16);
        endfunction

        // Moves the cursor by travel; returns 1 when it comes to rest inside the path.
        function bit walk(longint travel, output longint left);
            int unsigned n, ic, nx;
            longint unsigned len, s, remain;
            n = points_in_use();
            left = 0;
            if (travel == 0 || n == 0) return 0;
            if (n == 1) begin
                seg_idx = 0;
                seg_frac = 0;
                return 0;
            end
            if (seg_idx >= n) begin
                seg_idx = n - 1;
                seg_frac = 65536;
            end
            if (travel > 0) begin
                for (int unsigned i = seg_idx + 1; i < n; i++) begin
                    len = seg_len(i - 1, i);
                    s = (longint'(seg_frac) * len) >> 16;
                    remain = len - s;
                    if (longint'(travel) >= remain) begin
                        travel -= longint'(remain);
                        seg_idx = i;
                        seg_frac = 0;
                    end else begin
                        seg_frac = ((s + travel) << 16) / len;
                        return 1;
                    end
                end
                seg_idx = n - 1;
                seg_frac = 65536;
                left = travel;
                return 0;
            end
            // Backward: step down through segments until the distance runs out.
            while (1) begin
                ic = seg_idx;
                nx = (ic + 1 < n - 1) ? ic + 1 : n - 1;
                len = seg_len(ic, nx);
                s = (longint'(seg_frac) * len) >> 16;
                if (travel <= -longint'(s)) begin
                    travel += longint'(s);
                    if (seg_idx == 0) begin
                        seg_frac = 0;
                        left = travel;
                        return 0;
                    end
                    seg_idx--;
                    seg_frac = 65536;
                end else begin
                    seg_frac = ((longint'(s) + travel) << 16) / len;
                    return 1;
                end
            end
        endfunction

        // Called for every accepted request; queues the result it must produce.
        function void note_request(t_op op, logic [9:0] idx, int qx, int qy, int qz,
                                   int vx, int vy, int vz, int travel);
            walk_result_t r;
            longint left;
            bit in_path;
            int unsigned n, a;
            left = 0;
            in_path = 0;
            n = points_in_use();
            if (op == OP_LOAD) begin
                px[idx] = qx; py[idx] = qy; pz[idx] = qz;
                ux[idx] = vx; uy[idx] = vy; uz[idx] = vz;
            end else if (op == OP_SEEK || op == OP_MOVE) begin
                if (op == OP_SEEK) begin
                    if (travel < 0 && n >= 2) begin
                        seg_idx = n - 1;
                        seg_frac = 65536;
                    end else begin
                        seg_idx = 0;
                        seg_frac = 0;
                    end
                end
                in_path = walk(longint'(travel), left);
                if (in_path) left = 0;
            end
            r.leftover = left[31:0];
            r.in_path = in_path;
            r.seg = seg_idx[9:0];
            r.frac = seg_frac[16:0];
            {r.sx, r.sy, r.sz, r.sux, r.suy, r.suz} = '0;
            if (n > 0) begin
                if (seg_idx + 1 >= n) begin
                    a = n - 1;
                    r.sx = px[a]; r.sy = py[a]; r.sz = pz[a];
                    r.sux = ux[a]; r.suy = uy[a]; r.suz = uz[a];
                end else begin
                    a = seg_idx;
                    r.sx = interp(px[a], px[a + 1], seg_frac);
                    r.sy = interp(py[a], py[a + 1], seg_frac);
                    r.sz = interp(pz[a], pz[a + 1], seg_frac);
                    r.sux = interp(ux[a], ux[a + 1], seg_frac);
                    r.suy = interp(uy[a], uy[a + 1], seg_frac);
                    r.suz = interp(uz[a], uz[a + 1], seg_frac);
                end
            end
            due_q.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(walk_result_t act);
            walk_result_t e;
            if (due_q.size() == 0) begin
                $display("%0t unexpected result strobe, segment %0d", $time, act.seg);
                errors++;
                return;
            end
            e = due_q.pop_front();
            cmp("leftover", e.leftover, act.leftover);
            cmp("inside_res", e.in_path, act.in_path);
            cmp("cursor_segment", e.seg, act.seg);
            cmp("cursor_fraction", e.frac, act.frac);
            cmp("sample_x", e.sx, act.sx);
            cmp("sample_y", e.sy, act.sy);
            cmp("sample_z", e.sz, act.sz);
            cmp("sample_up_x", e.sux, act.sux);
            cmp("sample_up_y", e.suy, act.suy);
            cmp("sample_up_z", e.suz, act.suz);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [10:0]        i_cfg_wdata = '0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_operation = '0;
    logic [9:0]         i_point_index = '0;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic signed [17:0] i_up_x = '0;
    logic signed [17:0] i_up_y = '0;
    logic signed [17:0] i_up_z = '0;
    logic signed [31:0] i_distance = '0;
    logic               o_strobe;
    logic signed [31:0] o_leftover;
    logic               o_inside_res;
    logic [9:0]         o_cursor_segment;
    logic [16:0]        o_cursor_fraction;
    logic signed [31:0] o_sample_x;
    logic signed [31:0] o_sample_y;
    logic signed [31:0] o_sample_z;
    logic signed [17:0] o_sample_up_x;
    logic signed [17:0] o_sample_up_y;
    logic signed [17:0] o_sample_up_z;

    walk_scoreboard walk_sb = new();
    // Tracks which points have been loaded so no unwritten point is ever read.
    bit loaded[MAX_POINTS];

    polyline_distance_sampler_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_point_index     (i_point_index),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_up_x            (i_up_x),
        .i_up_y            (i_up_y),
        .i_up_z            (i_up_z),
        .i_distance        (i_distance),
        .o_strobe          (o_strobe),
        .o_leftover        (o_leftover),
        .o_inside_res      (o_inside_res),
        .o_cursor_segment  (o_cursor_segment),
        .o_cursor_fraction (o_cursor_fraction),
        .o_sample_x        (o_sample_x),
        .o_sample_y        (o_sample_y),
        .o_sample_z        (o_sample_z),
        .o_sample_up_x     (o_sample_up_x),
        .o_sample_up_y     (o_sample_up_y),
        .o_sample_up_z     (o_sample_up_z)
    );

    always #4 i_clk = ~i_clk;

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        walk_result_t act;
        if (i_rst_n && o_strobe) begin
            act.leftover = o_leftover;
            act.in_path = o_inside_res;
            act.seg = o_cursor_segment;
            act.frac = o_cursor_fraction;
            act.sx = o_sample_x;
            act.sy = o_sample_y;
            act.sz = o_sample_z;
            act.sux = o_sample_up_x;
            act.suy = o_sample_up_y;
            act.suz = o_sample_up_z;
            walk_sb.check_result(act);
        end
    end

    // Issues one request after a random gap and returns in the time step where it
    // was accepted. start is lowered only when a gap follows, so it never gets two
    // assignments in one step.
    task automatic send_request(t_op op, logic [9:0] idx, int qx, int qy, int qz,
                                int vx, int vy, int vz, int travel);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_point_index <= idx;
        i_pos_x <= qx;
        i_pos_y <= qy;
        i_pos_z <= qz;
        i_up_x <= vx[17:0];
        i_up_y <= vy[17:0];
        i_up_z <= vz[17:0];
        i_distance <= travel;
        do @(posedge i_clk); while (busy);
        if (op == OP_LOAD) loaded[idx] = 1'b1;
        walk_sb.note_request(op, idx, qx, qy, qz, vx, vy, vz, travel);
    endtask

    // The point count changes only once every outstanding request has finished.
    task automatic write_point_count(logic [10:0] v);
        start <= 1'b0;
        while (walk_sb.pending()) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        walk_sb.set_count(v);
    endtask

    function automatic int rand_pos();
        case ($urandom_range(0, 3))
            0, 1: return $signed($urandom_range(0, 524288)) - 262144;
            2: return $urandom();
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic int rand_up();
        case ($urandom_range(0, 5))
            0: return 65536;
            1: return -65536;
            default: return $signed($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    function automatic int rand_dist();
        case ($urandom_range(0, 9))
            0, 1, 2: return $signed($urandom_range(0, 524288)) - 262144;
            3, 4: return $signed($urandom_range(0, 2097152)) - 1048576;
            5, 6: return $urandom();
            7: return 0;
            8: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom_range(0, 1) ? 65536 : -65536;
        endcase
    endfunction

    task automatic load_random_point(logic [9:0] idx);
        send_request(OP_LOAD, idx, rand_pos(), rand_pos(), rand_pos(),
                     rand_up(), rand_up(), rand_up(), $urandom());
    endtask

    initial begin
        int unsigned n;
        int pick;
        logic [10:0] counts[8];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty path: all samples zero, nothing moves.
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 65536);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, -65536);
        send_request(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 123);

        // Extreme points, then a repeated point that makes a zero-length segment.
        send_request(OP_LOAD, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     65536, 65536, 65536, 0);
        send_request(OP_LOAD, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     -65536, -65536, -65536, 0);
        send_request(OP_LOAD, 2, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     -65536, -65536, -65536, 0);
        send_request(OP_LOAD, 3, 65536, -131072, 0, 0, 65536, -1, 0);

        // A single point sends the cursor to the start.
        write_point_count(1);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, 5);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, -5);

        write_point_count(4);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, 65536);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 32'sh80000000);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 32'sh7fffffff);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, -1);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, -65536);
        send_request(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0);

        // Cursor left beyond a shrunken path must first snap to the end.
        write_point_count(2);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, -100);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, 0);

        // Random phases, each with its own short path.
        counts = '{2, 3, 5, 8, 16, 4, 1, 0};
        for (int ph = 0; ph < 8; ph++) begin
            n = counts[ph];
            if (ph == 5) n = $urandom_range(2, 16);
            for (int unsigned p = 0; p < n; p++)
                if (!loaded[p]) load_random_point(p);
            write_point_count(n);
            for (int it = 0; it < 110; it++) begin
                pick = $urandom_range(0, 19);
                if (pick < 4)
                    load_random_point(($urandom_range(0, 9) < 7 && n > 0) ?
                                      $urandom_range(0, n - 1) : $urandom_range(0, 1023));
                else if (pick < 9)
                    send_request(OP_SEEK, $urandom(), $urandom(), $urandom(), $urandom(),
                                 rand_up(), rand_up(), rand_up(), rand_dist());
                else if (pick < 18)
                    send_request(OP_MOVE, $urandom(), $urandom(), $urandom(), $urandom(),
                                 rand_up(), rand_up(), rand_up(), rand_dist());
                else
                    send_request(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
                                 rand_up(), rand_up(), rand_up(), rand_dist());
            end
        end

        // Full and oversized counts: long first and last segments keep every walk
        // on the two end segments, so only points 0, 1 and the last two are read.
        send_request(OP_LOAD, 0, 0, 0, 0, 65536, 0, 0, 0);
        send_request(OP_LOAD, 1, 32'sh00100000, 0, 0, 0, 65536, 0, 0);
        send_request(OP_LOAD, MAX_POINTS - 2, 0, 32'sh00100000, 0, 0, 0, 65536, 0);
        send_request(OP_LOAD, MAX_POINTS - 1, 0, 0, 0, -65536, 0, 0, 0);
        write_point_count(MAX_POINTS);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, 3 * 65536);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, -65536);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, -3 * 65536);
        send_request(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
        write_point_count(11'h7ff);
        send_request(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, -1);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 2 * 65536);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, -65536);
        send_request(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 65536);

        start <= 1'b0;
        while (walk_sb.pending()) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (walk_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pds_pkg.sv
hw/rtl/pds_point_mem.sv
hw/rtl/pds_arith.sv
hw/rtl/polyline_distance_sampler_top.sv
verif/polyline_distance_sampler_top_tb.sv
